// ----- rtl/aseqp_pkg.sv -----
// ----------------------------------------------------------------------------
// aseqp_pkg: shared definitions for the allocation sequence patcher
// Instruction encodings, configuration codes, queue sizing and the structs
// that travel between the configuration, rewrite and output queue blocks.
// ----------------------------------------------------------------------------
package aseqp_pkg;

    localparam int COUNT_WIDTH = 16;             // width of the saturating rewrite count
    localparam int WORD_W      = 32;
    localparam int REP_W       = 16;             // width of the replacements field
    localparam int OFF_W       = 13;
    localparam int MAX_RES     = 3;              // result words one input word can cause
    localparam int OQ_DEPTH    = 16;
    localparam int PTR_W       = $clog2(OQ_DEPTH);
    localparam int OQ_SLACK    = 2 * MAX_RES;    // room for the item in flight and the next one

    // configuration register indexes
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_CALL_OFF = 2'd1;
    localparam logic [1:0] CFG_LEAF_OFF = 2'd2;

    // modes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // window fill levels
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    // instruction encodings
    localparam logic [31:0] JMP_BASE     = 32'h8bc16000;
    localparam logic [31:0] ARITH_MSK    = 32'hffffc000;
    localparam logic [31:0] TADD_BITS    = 32'h83104000;
    localparam logic [31:0] SIZE_MSK     = 32'h00003fff;
    localparam logic [31:0] ADDOR_MSK    = 32'hc1effff8;
    localparam logic [31:0] ADDOR_G2     = 32'h8000a000;
    localparam logic [31:0] ADDOR_G4     = 32'h80012000;
    localparam logic [31:0] LEAF_BIT     = 32'h00100000;
    localparam logic [31:0] ADD_SIZE_OPC = 32'h84008000;
    localparam logic [31:0] MOV_SIZE_OPC = 32'h88100000;
    localparam logic [31:0] G2G4_DIFF    = 32'h00008000;

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [PTR_W:0]         t_level;

    typedef struct packed {
        logic             mode;
        logic [OFF_W-1:0] call_off;
        logic [OFF_W-1:0] leaf_off;
    } t_cfg;

    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             last;
        t_word            word;
    } t_oitem;

    typedef struct packed {
        logic [1:0]          num;    // result words written this cycle, 0 to 3
        t_oitem [MAX_RES-1:0] item;  // item[0] goes out first
    } t_push;

endpackage

// ----- rtl/alloc_sequence_patcher.sv -----
// ----------------------------------------------------------------------------
// alloc_sequence_patcher: heap allocation sequence rewriter
// Streams SPARC instruction words and inserts or removes profiling jumps
// in three-word allocation sequences, counting the rewrites per range.
// ----------------------------------------------------------------------------
// Usage: words enter on the s_axis channel, one per transaction, with tlast on
// the final word of a code range. They leave on m_axis in their original order,
// one per transaction; m_axis_tlast marks the final word of the range and
// m_axis_tdata[47:32] then carries the number of sequences rewritten in that
// range (saturating, zero on every other word). The block sustains one word per
// cycle in both directions while m_axis_tready stays high. A word that does not
// start or continue a candidate sequence passes through the input register and
// the result queue before it is offered on m_axis; words of a candidate
// sequence are held (up to two) until the next word decides them, so
// their latency stretches by the time the following words take to arrive. A
// sequence cut off by tlast goes out unchanged. Results collect in a 16-entry
// queue; s_axis_tready drops only when more than ten words wait there, i.e.
// when the downstream side stalls. Write mode and offsets through the cfg
// channel only while the block is idle; cfg writes are always taken at once.
// ----------------------------------------------------------------------------
module alloc_sequence_patcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] in_word
    input  logic                        s_axis_tlast,   // is_last
    // result words
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,   // [31:0] out_word, [47:32] replacements
    output logic                        m_axis_tlast,   // out_last
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [aseqp_pkg::OFF_W-1:0] i_cfg_wdata
);
    import aseqp_pkg::*;

    t_cfg   cfg;
    t_push  push;
    t_oitem head;
    logic   room;
    logic   take;

    // configuration never stalls
    assign o_cfg_ready = 1'b1;

    aseqp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // accept a word whenever the queue can absorb the worst case of this word
    // and the one still in the rewrite register
    assign s_axis_tready = room;
    assign take          = s_axis_tvalid && room;

    aseqp_rewrite u_rewrite (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_cfg   (cfg),
        .o_push  (push)
    );

    aseqp_oqueue u_oqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_room  (room)
    );

    assign m_axis_tdata = {head.rep, head.word};
    assign m_axis_tlast = head.last;

endmodule

// ----- rtl/aseqp_cfg.sv -----
// ----------------------------------------------------------------------------
// aseqp_cfg: configuration registers
// Decodes writes on the configuration channel into mode and jump offsets.
// ----------------------------------------------------------------------------
module aseqp_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [aseqp_pkg::OFF_W-1:0] i_cfg_wdata,
    output aseqp_pkg::t_cfg           o_cfg
);
    import aseqp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:     r_cfg.mode     <= i_cfg_wdata[0];
                CFG_CALL_OFF: r_cfg.call_off <= i_cfg_wdata;
                CFG_LEAF_OFF: r_cfg.leaf_off <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/aseqp_rewrite.sv -----
// ----------------------------------------------------------------------------
// aseqp_rewrite: input register, sequence window and rewrite logic
// Registers each accepted word, matches it against the held window and
// produces up to three result words per cycle for the output queue.
// ----------------------------------------------------------------------------
module aseqp_rewrite (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  aseqp_pkg::t_word i_word,
    input  logic            i_last,
    input  aseqp_pkg::t_cfg i_cfg,
    output aseqp_pkg::t_push o_push
);
    import aseqp_pkg::*;

    logic       r_in_vld;
    t_word      r_word;
    logic       r_last;
    logic [1:0] r_fill;
    t_word      r_w0;
    t_word      r_w1;
    t_count     r_cnt;

    logic [1:0] n_fill;
    t_word      n_w0;
    t_word      n_w1;
    t_count     n_cnt;
    t_push      push;

    t_word jmp_norm;
    t_word jmp_leaf;
    logic  x_first;
    logic  x_second;
    logic  x_third;

    assign jmp_norm = JMP_BASE + WORD_W'(i_cfg.call_off);
    assign jmp_leaf = JMP_BASE + WORD_W'(i_cfg.leaf_off);

    always_comb begin
        if (i_cfg.mode == MODE_ADD) begin
            x_first  = (r_word & ARITH_MSK) == TADD_BITS;
            x_second = (r_word & ADDOR_MSK) == ADDOR_G2;
            x_third  = (r_word & ARITH_MSK) == ADD_SIZE_OPC;
        end else begin
            x_first  = (r_word == jmp_leaf) || (r_word == jmp_norm);
            x_second = (r_word & ARITH_MSK) == MOV_SIZE_OPC;
            x_third  = (r_word & ADDOR_MSK) == ADDOR_G4;
        end
    end

    always_comb begin
        logic [1:0] n;
        n      = 2'd0;
        push   = '0;
        n_fill = r_fill;
        n_w0   = r_w0;
        n_w1   = r_w1;
        n_cnt  = r_cnt;

        if (r_in_vld) begin
            case (r_fill)
                FILL_ONE: begin
                    if (x_second) begin
                        n_w1   = r_word;
                        n_fill = FILL_TWO;
                    end else begin
                        push.item[n].word = r_w0;
                        n = n + 2'd1;
                        if (x_first) begin
                            n_w0   = r_word;
                            n_fill = FILL_ONE;
                        end else begin
                            n_fill = FILL_EMPTY;
                            push.item[n].word = r_word;
                            n = n + 2'd1;
                        end
                    end
                end
                FILL_TWO: begin
                    if (x_third) begin
                        if (i_cfg.mode == MODE_ADD) begin
                            push.item[0].word = r_w1[20] ? jmp_leaf : jmp_norm;
                            push.item[1].word = MOV_SIZE_OPC + (r_w0 & SIZE_MSK);
                            push.item[2].word = r_w1 + G2G4_DIFF;
                        end else begin
                            push.item[0].word = TADD_BITS + (r_w1 & SIZE_MSK);
                            push.item[1].word = r_word - G2G4_DIFF;
                            push.item[2].word = ADD_SIZE_OPC + (r_w1 & SIZE_MSK);
                        end
                        n = 2'd3;
                        if (r_cnt != '1) begin
                            n_cnt = r_cnt + t_count'(1);
                        end
                        n_fill = FILL_EMPTY;
                    end else begin
                        push.item[0].word = r_w0;
                        push.item[1].word = r_w1;
                        n = 2'd2;
                        if (x_first) begin
                            n_w0   = r_word;
                            n_fill = FILL_ONE;
                        end else begin
                            n_fill = FILL_EMPTY;
                            push.item[n].word = r_word;
                            n = n + 2'd1;
                        end
                    end
                end
                default: begin
                    if (x_first) begin
                        n_w0   = r_word;
                        n_fill = FILL_ONE;
                    end else begin
                        n_fill = FILL_EMPTY;
                        push.item[n].word = r_word;
                        n = n + 2'd1;
                    end
                end
            endcase

            // end of range: flush the window and close out the count
            if (r_last) begin
                if (n_fill != FILL_EMPTY) begin
                    push.item[n].word = n_w0;
                    n = n + 2'd1;
                end
                if (n_fill == FILL_TWO) begin
                    push.item[n].word = n_w1;
                    n = n + 2'd1;
                end
                push.item[n - 2'd1].last = 1'b1;
                push.item[n - 2'd1].rep  = REP_W'(n_cnt);
                n_fill = FILL_EMPTY;
                n_cnt  = '0;
            end
        end
        push.num = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_fill   <= FILL_EMPTY;
            r_cnt    <= '0;
        end else begin
            r_in_vld <= i_take;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0 <= n_w0;
        r_w1 <= n_w1;
        if (i_take) begin
            r_word <= i_word;
            r_last <= i_last;
        end
    end

    assign o_push = push;

endmodule

// ----- rtl/aseqp_oqueue.sv -----
// ----------------------------------------------------------------------------
// aseqp_oqueue: result word queue
// Takes up to three words per cycle, hands out one per transaction and
// reports whether room remains for two more input words.
// ----------------------------------------------------------------------------
module aseqp_oqueue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aseqp_pkg::t_push  i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output aseqp_pkg::t_oitem o_head,
    output logic              o_room
);
    import aseqp_pkg::*;

    t_oitem r_mem [OQ_DEPTH];
    t_ptr   r_wp;
    t_ptr   r_rp;
    t_level r_lvl;

    logic   pop;

    assign pop = i_pop && (r_lvl != '0);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_push.num) begin
                r_mem[t_ptr'(r_wp + t_ptr'(k))] <= i_push.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            r_wp  <= r_wp + t_ptr'(i_push.num);
            r_rp  <= r_rp + t_ptr'(pop);
            r_lvl <= r_lvl + t_level'(i_push.num) - t_level'(pop);
        end
    end

    assign o_valid = (r_lvl != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room  = (r_lvl <= t_level'(OQ_DEPTH - OQ_SLACK));

endmodule
